// ----- hw/rtl/ima_pkg.sv -----
// ima_pkg: shared types, constants and tables of the ima adpcm encoder
// no dependencies; used by the interfaces, the quantizer and the top level
package ima_pkg;

	typedef logic signed [15:0] sample_t;
	typedef logic [6:0] step_idx_t;
	typedef logic [14:0] step_t;
	typedef logic [3:0] nibble_t;
	typedef logic [7:0] byte_t;
	typedef logic [15:0] cfg_data_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_INIT_PREDICTOR  = 1'b0,
		CFG_INIT_STEP_INDEX = 1'b1
	} cfg_idx_t;

	localparam sample_t   SampleMax  = 16'sh7fff;
	localparam sample_t   SampleMin  = 16'sh8000;
	localparam step_idx_t MaxStepIdx = 7'd88;

	// predictor and step index as one bundle
	typedef struct packed {
		sample_t   predictor;
		step_idx_t step_index;
	} enc_state_t;

	localparam step_t StepTable [0:88] = '{
		15'd7,     15'd8,     15'd9,     15'd10,    15'd11,
		15'd12,    15'd13,    15'd14,    15'd16,    15'd17,
		15'd19,    15'd21,    15'd23,    15'd25,    15'd28,
		15'd31,    15'd34,    15'd37,    15'd41,    15'd45,
		15'd50,    15'd55,    15'd60,    15'd66,    15'd73,
		15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
		15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
		15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
		15'd337,   15'd371,   15'd408,   15'd449,   15'd494,
		15'd544,   15'd598,   15'd658,   15'd724,   15'd796,
		15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,
		15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
		15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,
		15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
		15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,
		15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
		15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
		15'd24623, 15'd27086, 15'd29794, 15'd32767
	};

	// step index adjustment by 3-bit magnitude
	localparam logic signed [4:0] IndexAdjust [0:7] = '{
		-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
	};

endpackage

// ----- hw/rtl/ima_if.sv -----
// ima_if: valid/ready channel interfaces of the ima adpcm encoder
// depends on ima_pkg
interface ima_in_if;
	import ima_pkg::*;
	logic    valid;
	logic    ready;
	sample_t pcm_sample;
	logic    end_of_run;
	logic    restart;
	modport source (output valid, pcm_sample, end_of_run, restart, input ready);
	modport sink   (input valid, pcm_sample, end_of_run, restart, output ready);
endinterface

interface ima_out_if;
	import ima_pkg::*;
	logic  valid;
	logic  ready;
	byte_t packed_codes;
	logic  run_last;
	modport source (output valid, packed_codes, run_last, input ready);
	modport sink   (input valid, packed_codes, run_last, output ready);
endinterface

interface ima_cfg_if;
	import ima_pkg::*;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	cfg_data_t  data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ima_adpcm_encoder.sv -----
// ima_adpcm_encoder: 4-bit ima adpcm encoder, two codes packed per byte
// the input register holds a sample, the result register the byte that it completes
// throughput: one sample per cycle, unless a byte is due while the output stalls
// a byte leaves on every second sample, or on a sample that ends a run
// arst_n clears predictor, step index, pairing state, config registers and valids
// depends on ima_pkg, ima_if and ima_quant
module ima_adpcm_encoder (
	input  logic     clk,
	input  logic     arst_n,
	ima_in_if.sink   samples,
	ima_out_if.source codes,
	ima_cfg_if.sink  cfg
);
	import ima_pkg::*;

	// input register
	logic       valid_s1;
	sample_t    sample_s1;
	logic       last_s1;
	logic       restart_s1;

	// encoder state
	sample_t    pred_q;
	step_idx_t  idx_q;
	nibble_t    held_q;
	logic       pending_q;

	// restart values, index already clamped to 0..88
	sample_t    init_pred_q;
	step_idx_t  init_idx_q;

	// result register
	logic       out_valid_q;
	byte_t      out_codes_q;
	logic       out_last_q;

	enc_state_t state_cur, state_init, state_next;
	nibble_t    code;
	logic       emit;
	logic       advance;

	// the item in the input register makes a byte when it pairs or ends a run
	assign emit    = pending_q || last_s1;
	// an item that makes no byte always moves on; otherwise it needs room
	assign advance = valid_s1 && (!emit || !out_valid_q || codes.ready);

	assign samples.ready = !valid_s1 || advance;
	assign cfg.ready     = 1'b1;

	assign codes.valid        = out_valid_q;
	assign codes.packed_codes = out_codes_q;
	assign codes.run_last     = out_last_q;

	assign state_cur  = '{predictor: pred_q, step_index: idx_q};
	assign state_init = '{predictor: init_pred_q, step_index: init_idx_q};

	ima_quant u_quant (
		.sample     (sample_s1),
		.restart    (restart_s1),
		.state_cur  (state_cur),
		.state_init (state_init),
		.state_next (state_next),
		.code       (code)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_pred_q <= '0;
			init_idx_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_INIT_PREDICTOR: begin
					init_pred_q <= cfg.data;
				end
				CFG_INIT_STEP_INDEX: begin
					// out-of-range index in the low seven bits saturates when written
					init_idx_q <= (cfg.data[6:0] > MaxStepIdx) ? MaxStepIdx : cfg.data[6:0];
				end
			endcase
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_s1  <= samples.pcm_sample;
			last_s1    <= samples.end_of_run;
			restart_s1 <= samples.restart;
		end
	end

	// encoder state and nibble pairing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q    <= '0;
			idx_q     <= '0;
			held_q    <= '0;
			pending_q <= 1'b0;
		end else if (advance) begin
			pred_q <= state_next.predictor;
			idx_q  <= state_next.step_index;
			if (!pending_q) begin
				held_q    <= code;
				pending_q <= !last_s1;
			end else begin
				pending_q <= 1'b0;
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (codes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload: earlier code high, a flushed half byte gets a zero low nibble
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_codes_q <= pending_q ? {held_q, code} : {code, 4'b0000};
			out_last_q  <= last_s1;
		end
	end

endmodule

// ----- hw/rtl/ima_quant.sv -----
// ima_quant: one-sample adpcm quantizer and predictor/step index update
// depends on ima_pkg
module ima_quant (
	input  ima_pkg::sample_t    sample,
	input  logic                restart,
	input  ima_pkg::enc_state_t state_cur,
	input  ima_pkg::enc_state_t state_init,
	output ima_pkg::enc_state_t state_next,
	output ima_pkg::nibble_t    code
);
	import ima_pkg::*;

	enc_state_t              base;
	step_t                   step;
	logic signed [16:0]      diff;
	logic                    neg;
	logic [16:0]             mag;
	logic [16:0]             st0, st1, st2;
	logic [16:0]             mag1, mag2;
	logic                    b2, b1, b0;
	logic [16:0]             vpdiff;
	logic signed [17:0]      pred_ext;
	logic signed [17:0]      pred_new;
	logic signed [4:0]       adj;
	logic signed [7:0]       idx_new;

	assign base = restart ? state_init : state_cur;
	assign step = StepTable[base.step_index];

	assign diff = {sample[15], sample} - {base.predictor[15], base.predictor};
	assign neg  = diff[16];
	assign mag  = neg ? 17'(-diff) : 17'(diff);

	// successive compare against step, step/2, step/4
	assign st0  = {2'b00, step};
	assign st1  = {3'b000, step[14:1]};
	assign st2  = {4'b0000, step[14:2]};
	assign b2   = mag >= st0;
	assign mag1 = b2 ? mag - st0 : mag;
	assign b1   = mag1 >= st1;
	assign mag2 = b1 ? mag1 - st1 : mag1;
	assign b0   = mag2 >= st2;

	assign vpdiff = {5'b00000, step[14:3]} + (b2 ? st0 : 17'd0)
		+ (b1 ? st1 : 17'd0) + (b0 ? st2 : 17'd0);

	assign pred_ext = {{2{base.predictor[15]}}, base.predictor};
	assign pred_new = neg ? pred_ext - $signed({1'b0, vpdiff})
		: pred_ext + $signed({1'b0, vpdiff});

	assign code = {neg, b2, b1, b0};

	assign adj     = IndexAdjust[code[2:0]];
	assign idx_new = $signed({1'b0, base.step_index}) + {{3{adj[4]}}, adj};

	always_comb begin
		// saturate predictor to 16 bits
		if (pred_new > 18'sd32767) begin
			state_next.predictor = SampleMax;
		end else if (pred_new < -18'sd32768) begin
			state_next.predictor = SampleMin;
		end else begin
			state_next.predictor = pred_new[15:0];
		end
		// clamp step index to 0..88
		if (idx_new[7]) begin
			state_next.step_index = '0;
		end else if (idx_new[6:0] > MaxStepIdx) begin
			state_next.step_index = MaxStepIdx;
		end else begin
			state_next.step_index = idx_new[6:0];
		end
	end

endmodule

// ----- hw/rtl/ima_checker.sv -----
// ima_checker: port-level assertions for ima_adpcm_encoder
// bound to the top level below; no package dependency
module ima_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_codes,
	input logic       out_last,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	// a stalled byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_codes) && $stable(out_last))
		else $error("result item changed while stalled");

	// with no byte waiting the input side never stalls
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// configuration writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

	// ready does not drop while the input side waits and the output drains
	a_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && out_ready |-> in_ready)
		else $error("input stalled while output drains");

endmodule

bind ima_adpcm_encoder ima_checker u_ima_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (codes.valid),
	.out_ready (codes.ready),
	.out_codes (codes.packed_codes),
	.out_last  (codes.run_last),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);
